### design/wrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF parser package
// Shared constants and the queue entry type of the WAV stream parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [3:0]  HEADER_BYTES = 4'd12;
  localparam logic [31:0] FMT_MIN      = 32'd16;

  localparam logic KIND_PCM    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NO_RIFF   = 3'd2;
  localparam logic [2:0] ST_NO_WAVE   = 3'd3;
  localparam logic [2:0] ST_FMT_BAD   = 3'd4;
  localparam logic [2:0] ST_DATA_TRUNC = 3'd5;
  localparam logic [2:0] ST_MISSING   = 3'd6;
  localparam logic [2:0] ST_NOT_PCM   = 3'd7;

  typedef struct packed {
    logic        has_pcm;
    logic [7:0]  pcm_byte;
    logic        has_rep;
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } entry_t;

endpackage

### design/wrp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF parser channels
// Valid/ready channels for input bytes and result beats.
// ----------------------------------------------------------------------------
interface wrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface wrp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  pcm_byte;
  logic [2:0]  status;
  logic [15:0] audio_format;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [31:0] data_length;
  logic        final_flag;

  modport source (output valid, output kind, output pcm_byte, output status,
                  output audio_format, output channel_count, output sample_rate,
                  output sample_bits, output data_length, output final_flag,
                  input ready);
  modport sink (input valid, input kind, input pcm_byte, input status,
                input audio_format, input channel_count, input sample_rate,
                input sample_bits, input data_length, input final_flag,
                output ready);
endinterface

### design/wrp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF parser queue
// Register queue of parsed entries between the front and back parts.
// ----------------------------------------------------------------------------
module wrp_fifo #(
  parameter int Depth = wrp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wrp_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output wrp_pkg::entry_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  wrp_pkg::entry_t mem_r [Depth];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CW'(Depth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");
`endif

endmodule

### design/wrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF parser front
// Walks the RIFF header and chunks one byte per beat and queues results.
// ----------------------------------------------------------------------------
module wrp_front (
  input  logic            clk,
  input  logic            rst_n,
  wrp_in_if.sink          in_ch,
  input  logic            full,
  output logic            push,
  output wrp_pkg::entry_t push_data
);

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_ID    = 4'd3;
  localparam logic [3:0] PH_LEN   = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_DATA  = 4'd6;
  localparam logic [3:0] PH_SKIP  = 4'd7;
  localparam logic [3:0] PH_PAD   = 4'd8;
  localparam logic [3:0] PH_HALT  = 4'd9;

  localparam logic [1:0] CK_OTHER = 2'd0;
  localparam logic [1:0] CK_FMT   = 2'd1;
  localparam logic [1:0] CK_DATA  = 2'd2;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dlen_r, dlen_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  ckind_r, ckind_nxt;
  logic [31:0] off;
  logic        acc;

  assign in_ch.ready = !full;
  assign acc = in_ch.valid && in_ch.ready;
  assign off = clen_r - left_r;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    tag_nxt   = tag_r;
    clen_nxt  = clen_r;
    fmt_nxt   = fmt_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    dlen_nxt  = dlen_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    ckind_nxt = ckind_r;
    push      = 1'b0;
    push_data = '0;
    if (acc) begin
      if (cnt_r < wrp_pkg::HEADER_BYTES) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      case (phase_r)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_LEN: begin
          tag_nxt  = {in_ch.in_byte, tag_r[31:8]};
          left_nxt = left_r - 1'b1;
          if (left_nxt == '0) begin
            left_nxt = 32'd4;
            case (phase_r)
              PH_RIFF: begin
                if (tag_nxt != wrp_pkg::TAG_RIFF) begin
                  err_nxt   = wrp_pkg::ST_NO_RIFF;
                  phase_nxt = PH_HALT;
                end else begin
                  phase_nxt = PH_RSIZE;
                end
              end
              PH_RSIZE: begin
                phase_nxt = PH_WAVE;
              end
              PH_WAVE: begin
                if (tag_nxt != wrp_pkg::TAG_WAVE) begin
                  err_nxt   = wrp_pkg::ST_NO_WAVE;
                  phase_nxt = PH_HALT;
                end else begin
                  phase_nxt = PH_ID;
                end
              end
              PH_ID: begin
                if (tag_nxt == wrp_pkg::TAG_FMT) begin
                  ckind_nxt = CK_FMT;
                end else if (tag_nxt == wrp_pkg::TAG_DATA) begin
                  ckind_nxt = CK_DATA;
                end else begin
                  ckind_nxt = CK_OTHER;
                end
                phase_nxt = PH_LEN;
              end
              default: begin
                clen_nxt = tag_nxt;
                if (ckind_r == CK_FMT) begin
                  if (tag_nxt < wrp_pkg::FMT_MIN) begin
                    err_nxt   = wrp_pkg::ST_FMT_BAD;
                    phase_nxt = PH_HALT;
                  end else begin
                    phase_nxt = PH_FMT;
                    left_nxt  = tag_nxt;
                  end
                end else begin
                  if (ckind_r == CK_DATA) begin
                    dlen_nxt    = tag_nxt;
                    seen_nxt[1] = 1'b1;
                  end
                  if (tag_nxt == '0) begin
                    phase_nxt = PH_ID;
                  end else begin
                    phase_nxt = (ckind_r == CK_DATA) ? PH_DATA : PH_SKIP;
                    left_nxt  = tag_nxt;
                  end
                end
              end
            endcase
          end
        end
        PH_FMT, PH_DATA, PH_SKIP: begin
          if (phase_r == PH_FMT && off[31:4] == '0) begin
            case (off[3:0])
              4'd0:  fmt_nxt[7:0]    = in_ch.in_byte;
              4'd1:  fmt_nxt[15:8]   = in_ch.in_byte;
              4'd2:  chan_nxt[7:0]   = in_ch.in_byte;
              4'd3:  chan_nxt[15:8]  = in_ch.in_byte;
              4'd4:  rate_nxt[7:0]   = in_ch.in_byte;
              4'd5:  rate_nxt[15:8]  = in_ch.in_byte;
              4'd6:  rate_nxt[23:16] = in_ch.in_byte;
              4'd7:  rate_nxt[31:24] = in_ch.in_byte;
              4'd14: bits_nxt[7:0]   = in_ch.in_byte;
              4'd15: bits_nxt[15:8]  = in_ch.in_byte;
              default: ;
            endcase
          end
          if (phase_r == PH_DATA) begin
            push_data.has_pcm  = 1'b1;
            push_data.pcm_byte = in_ch.in_byte;
          end
          left_nxt = left_r - 1'b1;
          if (left_nxt == '0) begin
            if (phase_r == PH_FMT) begin
              seen_nxt[0] = 1'b1;
            end
            phase_nxt = clen_r[0] ? PH_PAD : PH_ID;
            left_nxt  = 32'd4;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_ID;
          left_nxt  = 32'd4;
        end
        default: ;
      endcase

      if (in_ch.is_last) begin
        if (phase_nxt == PH_FMT && left_nxt != '0) begin
          err_nxt = wrp_pkg::ST_FMT_BAD;
        end else if (phase_nxt == PH_DATA && left_nxt != '0) begin
          err_nxt = wrp_pkg::ST_DATA_TRUNC;
        end
        push_data.has_rep = 1'b1;
        if (cnt_nxt < wrp_pkg::HEADER_BYTES) begin
          push_data.status = wrp_pkg::ST_SHORT;
        end else if (err_nxt != wrp_pkg::ST_OK) begin
          push_data.status = err_nxt;
        end else if (seen_nxt != 2'b11) begin
          push_data.status = wrp_pkg::ST_MISSING;
        end else if (fmt_nxt != 16'd1) begin
          push_data.status = wrp_pkg::ST_NOT_PCM;
        end else begin
          push_data.status = wrp_pkg::ST_OK;
        end
        push_data.audio_format  = fmt_nxt;
        push_data.channel_count = chan_nxt;
        push_data.sample_rate   = rate_nxt;
        push_data.sample_bits   = bits_nxt;
        push_data.data_length   = dlen_nxt;

        phase_nxt = PH_RIFF;
        left_nxt  = 32'd4;
        tag_nxt   = '0;
        clen_nxt  = '0;
        fmt_nxt   = '0;
        chan_nxt  = '0;
        rate_nxt  = '0;
        bits_nxt  = '0;
        dlen_nxt  = '0;
        seen_nxt  = '0;
        err_nxt   = wrp_pkg::ST_OK;
        cnt_nxt   = '0;
        ckind_nxt = CK_OTHER;
      end
      push = push_data.has_pcm || push_data.has_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      left_r  <= 32'd4;
      tag_r   <= '0;
      clen_r  <= '0;
      fmt_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      dlen_r  <= '0;
      seen_r  <= '0;
      err_r   <= wrp_pkg::ST_OK;
      cnt_r   <= '0;
      ckind_r <= CK_OTHER;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      tag_r   <= tag_nxt;
      clen_r  <= clen_nxt;
      fmt_r   <= fmt_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      dlen_r  <= dlen_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
      ckind_r <= ckind_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.is_last) |=> (phase_r == PH_RIFF && cnt_r == '0))
    else $error("parser did not restart after the last byte");
`endif

endmodule

### design/wrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF parser back
// Splits each queued entry into its data beat, its report beat, or both.
// ----------------------------------------------------------------------------
module wrp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  wrp_pkg::entry_t head,
  output logic            pop,
  wrp_out_if.source       out_ch
);

  logic pcm_done_r, pcm_done_nxt;
  logic pcm_beat;
  logic beat_acc;

  assign pcm_beat = head.has_pcm && !pcm_done_r;
  assign beat_acc = out_ch.valid && out_ch.ready;
  assign pop      = beat_acc && (!pcm_beat || !head.has_rep);

  assign out_ch.valid         = !empty;
  assign out_ch.kind          = pcm_beat ? wrp_pkg::KIND_PCM : wrp_pkg::KIND_REPORT;
  assign out_ch.pcm_byte      = pcm_beat ? head.pcm_byte : 8'd0;
  assign out_ch.status        = pcm_beat ? wrp_pkg::ST_OK : head.status;
  assign out_ch.audio_format  = pcm_beat ? 16'd0 : head.audio_format;
  assign out_ch.channel_count = pcm_beat ? 16'd0 : head.channel_count;
  assign out_ch.sample_rate   = pcm_beat ? 32'd0 : head.sample_rate;
  assign out_ch.sample_bits   = pcm_beat ? 16'd0 : head.sample_bits;
  assign out_ch.data_length   = pcm_beat ? 32'd0 : head.data_length;
  assign out_ch.final_flag    = !pcm_beat;

  always_comb begin
    pcm_done_nxt = pcm_done_r;
    if (pop) begin
      pcm_done_nxt = 1'b0;
    end else if (beat_acc && pcm_beat) begin
      pcm_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcm_done_r <= 1'b0;
    end else begin
      pcm_done_r <= pcm_done_nxt;
    end
  end

endmodule

### design/wav_riff_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV RIFF stream parser
// Each result is registered in the queue as its byte is taken and is offered
// from the queue head. Throughput: one byte per cycle while the queue is not full;
// a data byte that also ends the image yields two beats from the back part's single output port.
// Reset: synchronous rst_n restarts the parser at the RIFF tag and empties
// the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser #(
  parameter int FIFO_DEPTH = wrp_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  wrp_in_if.sink    in_ch,
  wrp_out_if.source out_ch
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  wrp_pkg::entry_t push_data;
  wrp_pkg::entry_t head;

  wrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  wrp_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  wrp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  a_pcm_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == wrp_pkg::KIND_PCM) |->
      (out_ch.final_flag == 1'b0 && out_ch.status == wrp_pkg::ST_OK))
    else $error("data beat carries report fields");
  a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == wrp_pkg::KIND_REPORT) |->
      (out_ch.final_flag == 1'b1 && out_ch.pcm_byte == 8'd0))
    else $error("report beat malformed");
`endif

endmodule
